// ===== hdl/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

   // Geometry defaults
   localparam int COLUMNS_DEFAULT   = 80;
   localparam int ROWS_DEFAULT      = 25;
   localparam int TAB_WIDTH_DEFAULT = 8;

   // Field widths of the item and result
   localparam int ACTION_W        = 2;
   localparam int BYTE_W          = 8;
   localparam int CELL_INDEX_W    = 11;
   localparam int CURSOR_ROW_W    = 5;
   localparam int CURSOR_COLUMN_W = 7;
   localparam int CURSOR_POS_W    = 11;
   localparam int CELL_W          = 2 * BYTE_W;

   // Attribute used for blanking until software writes the register
   localparam logic [BYTE_W-1:0] BLANK_COLOR_RESET = 8'h07;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Control characters
   localparam logic [BYTE_W-1:0] CHR_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CHR_NL    = 8'd10;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'd32;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic [BYTE_W-1:0]       char_code;
      logic [BYTE_W-1:0]       color;
      logic [CELL_INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_ROW_W-1:0]    cursor_row;
      logic [CURSOR_COLUMN_W-1:0] cursor_column;
      logic [CURSOR_POS_W-1:0]    cursor_pos;
      logic [BYTE_W-1:0]          cell_char;
      logic [BYTE_W-1:0]          cell_color;
      logic                       scrolled;
   } rsp_type;

endpackage

// ===== hdl/text_console_char_writer.sv =====
`timescale 1ns / 1ps

// Text console engine: a ROWS x COLUMNS store of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor.
// Input channel req_*: one item is an action (put character, clear screen,
// read cell). Result channel rsp_*: exactly one result per item, carrying
// the cursor after the item and, for a read, the cell contents.
// csr_write_enable/csr_write_data set the attribute used for blanked cells.
// Steps per item, with N = ROWS*COLUMNS: accept, then execute. A put that
// scrolls then copies N - COLUMNS cells up a row and blanks the last row; a
// clear blanks all N cells. Both then pass through a respond state.
// The cell store has one read and one write port, so scroll moves one cell
// per cycle and blanking writes one cell per cycle.
// Reset (synchronous) homes the cursor and starts a blanking pass over all
// N cells; req_ready stays low until it finishes. Register writes are taken
// at any time.
// Results sit in an output register; a new item is accepted while a result
// waits, and the following result holds until rsp_ready frees the register.
module text_console_char_writer #(
   parameter int COLUMNS   = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS      = tccw_pkg::ROWS_DEFAULT,
   parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tccw_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tccw_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [tccw_pkg::BYTE_W-1:0]   csr_write_data
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ROW_NW     = $clog2(ROWS + 1);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int NEXT_W     = $clog2(COLUMNS + TAB_WIDTH);
   localparam int TAB_STOPS  = (COLUMNS - 1) / TAB_WIDTH + 1;
   localparam int CMP_W      = (ADDR_W + 1 > CELL_INDEX_W) ? ADDR_W + 1 : CELL_INDEX_W;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_FILL,
      ST_RESPOND
   } state_type;

   // Control and payload registers
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [BYTE_W-1:0]  blank_color_ff;
   req_type            item_ff, item_in;
   logic               read_ok_ff, read_ok_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Cell store
   logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
   logic [CELL_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   // Execute-stage results
   logic [ADDR_W-1:0]  cur_addr;
   logic [NEXT_W-1:0]  tab_next;
   logic [NEXT_W-1:0]  col_step;
   logic [ROW_NW-1:0]  row_step;
   logic [ROW_W-1:0]   exec_row;
   logic [COL_W-1:0]   exec_col;
   logic [ADDR_W-1:0]  exec_pos;
   logic               exec_we;
   logic [ADDR_W-1:0]  exec_waddr;
   logic [CELL_W-1:0]  exec_wdata;
   logic               exec_scroll;
   logic               exec_clear;
   logic [BYTE_W-1:0]  exec_char;
   logic [BYTE_W-1:0]  exec_color;
   rsp_type            exec_rsp;

   logic               req_in_range;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_in_range = (CMP_W'(req_data.cell_index) < CMP_W'(CELL_COUNT));
   assign cur_addr     = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   // Next tab stop: first multiple of TAB_WIDTH above the column
   always_comb begin
      tab_next = NEXT_W'(TAB_WIDTH);
      for (int j = 0; j < TAB_STOPS; j++) begin
         if (NEXT_W'(col_ff) >= NEXT_W'(j * TAB_WIDTH)) begin
            tab_next = NEXT_W'((j + 1) * TAB_WIDTH);
         end
      end
   end

   // Execute one item against the cursor and the cell store
   always_comb begin
      col_step    = NEXT_W'(col_ff);
      row_step    = ROW_NW'(row_ff);
      exec_we     = 1'b0;
      exec_waddr  = cur_addr;
      exec_wdata  = {blank_color_ff, CHR_SPACE};
      exec_scroll = 1'b0;
      exec_clear  = 1'b0;
      exec_char   = '0;
      exec_color  = '0;
      exec_row    = row_ff;
      exec_col    = col_ff;
      case (item_ff.action)
         ACT_PUT: begin
            case (item_ff.char_code)
               CHR_NL: begin
                  row_step = ROW_NW'(row_ff) + ROW_NW'(1);
                  col_step = '0;
               end
               CHR_TAB: begin
                  col_step = tab_next;
               end
               CHR_CR: begin
                  col_step = '0;
               end
               CHR_BS: begin
                  // backspace at column zero does nothing
                  if (col_ff != '0) begin
                     col_step   = NEXT_W'(col_ff) - NEXT_W'(1);
                     exec_we    = 1'b1;
                     exec_waddr = cur_addr - ADDR_W'(1);
                  end
               end
               default: begin
                  exec_we    = 1'b1;
                  exec_wdata = {item_ff.color, item_ff.char_code};
                  col_step   = NEXT_W'(col_ff) + NEXT_W'(1);
               end
            endcase
            // line wrap
            if (col_step >= NEXT_W'(COLUMNS)) begin
               row_step = ROW_NW'(row_ff) + ROW_NW'(1);
               col_step = '0;
            end
            // past the last row: scroll, stay on the last row
            if (row_step >= ROW_NW'(ROWS)) begin
               row_step    = ROW_NW'(ROWS - 1);
               exec_scroll = 1'b1;
            end
            exec_row = ROW_W'(row_step);
            exec_col = COL_W'(col_step);
         end
         ACT_CLEAR: begin
            exec_clear = 1'b1;
            exec_row   = '0;
            exec_col   = '0;
         end
         ACT_READ: begin
            if (read_ok_ff) begin
               exec_char  = rd_data_ff[BYTE_W-1:0];
               exec_color = rd_data_ff[CELL_W-1:BYTE_W];
            end
         end
         default: begin
         end
      endcase
   end

   assign exec_pos = ADDR_W'(exec_row) * ADDR_W'(COLUMNS) + ADDR_W'(exec_col);

   always_comb begin
      exec_rsp.cursor_row    = CURSOR_ROW_W'(exec_row);
      exec_rsp.cursor_column = CURSOR_COLUMN_W'(exec_col);
      exec_rsp.cursor_pos    = CURSOR_POS_W'(exec_pos);
      exec_rsp.cell_char     = exec_char;
      exec_rsp.cell_color    = exec_color;
      exec_rsp.scrolled      = exec_scroll;
   end

   // Sequencer: next state, memory port control, result loading
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      item_in      = item_ff;
      read_ok_in   = read_ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(cnt_ff);
      mem_wdata    = {blank_color_ff, CHR_SPACE};
      mem_raddr    = '0;
      case (state_ff)
         ST_INIT: begin
            // reset pass blanks with the reset attribute
            mem_we    = 1'b1;
            mem_wdata = {BLANK_COLOR_RESET, CHR_SPACE};
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            // read is issued at accept, data is ready in execute
            mem_raddr = req_in_range ? ADDR_W'(req_data.cell_index) : '0;
            if (req_valid) begin
               item_in    = req_data;
               read_ok_in = req_in_range;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            row_in    = exec_row;
            col_in    = exec_col;
            mem_we    = exec_we;
            mem_waddr = exec_waddr;
            mem_wdata = exec_wdata;
            res_in    = exec_rsp;
            if (exec_scroll) begin
               cnt_in   = '0;
               state_in = ST_SCROLL;
            end else if (exec_clear) begin
               cnt_in   = '0;
               state_in = ST_FILL;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = exec_rsp;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCROLL: begin
            // read cell cnt+COLUMNS, write it to cell cnt in the next cycle
            if (cnt_ff < CNT_W'(COPY_COUNT)) begin
               mem_raddr = ADDR_W'(cnt_ff) + ADDR_W'(COLUMNS);
            end
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(cnt_ff - CNT_W'(1));
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff == CNT_W'(COPY_COUNT)) begin
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_RESPOND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      read_ok_ff  <= read_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Blanking attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_color_ff <= BLANK_COLOR_RESET;
      end else if (csr_write_enable) begin
         blank_color_ff <= csr_write_data;
      end
   end

   // Cell store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

endmodule

// ===== hdl/tccw_checker.sv =====
`timescale 1ns / 1ps

module tccw_checker #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tccw_pkg::rsp_type rsp_data
);
   import tccw_pkg::*;

   // Reset starts the blanking pass with nothing pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result present right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Linear position matches row and column
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ROWS > 32) || (rsp_data.cursor_pos == CURSOR_POS_W'(
         int'(rsp_data.cursor_row) * COLUMNS + int'(rsp_data.cursor_column))))
      else $error("cursor_pos does not match row and column");

   // Column always inside the line
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.cursor_column) < COLUMNS)
      else $error("cursor column out of range");

   // A scroll leaves the cursor on the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scrolled |-> rsp_data.cursor_row == CURSOR_ROW_W'(ROWS - 1))
      else $error("scroll did not leave cursor on last row");

endmodule

bind text_console_char_writer tccw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
